>>> rtl/plt_pkg.sv
// Package for the positional list table: default depth, value width,
// action and status codes and the sequencer state type.
// No dependencies; used by plt_ram and positional_list_table_top.
`default_nettype none

package plt_pkg;

  // Default list capacity and stored value width
  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;

  // Fixed port widths
  localparam int ACTION_W = 2;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_POS   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SCAN
  } state_t;

endpackage

`default_nettype wire

>>> rtl/positional_list_table_top.sv
// Top level of the positional list table: command sequencer, count and
// result registers around the entry store. Depends on plt_pkg, plt_ram.
`default_nettype none

// Usage
//   Command channel: drive action, position and item_value with start
//   high; the command transfers at the rising edge where start is high
//   and busy is low. busy is high while a command walks the store.
//   Result channel: done is high for exactly one cycle with status,
//   found_index and entry_count; the receiver must take it then.
// Sequencing
//   Full list, bad position, empty find, delete of the last entry and
//   unused action codes: result in the cycle after the transfer, busy
//   stays low.
//   Insert: moves entries up from the end, then writes the new value.
//   Delete: moves the entries above the hole down, then drops the count.
//   Find: compares entries from index 0 up to a hit or the list end.
//   Each work cycle moves or compares one entry through the single read
//   port of the store; the result strobe follows the last work cycle, and
//   a new command may transfer in that same cycle.
// Reset
//   rst clears the count and the sequencer; entry contents are left as
//   they are, since only entries below the count are ever read.
module positional_list_table_top #(
  parameter int DEPTH = plt_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [plt_pkg::ACTION_W-1:0]  action,
  input  wire logic [plt_pkg::POS_W-1:0]     position,
  input  wire logic [plt_pkg::VALUE_W-1:0]   item_value,
  output logic                               done,
  output logic      [plt_pkg::STATUS_W-1:0]  status,
  output logic      [plt_pkg::FOUND_W-1:0]   found_index,
  output logic      [plt_pkg::COUNT_W-1:0]   entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > plt_pkg::POS_W) ? CW : plt_pkg::POS_W) + 1;

  plt_pkg::state_t state, state_next;

  logic [CW-1:0]               cnt, cnt_next;
  logic [AW-1:0]               ptr, ptr_next;
  logic [AW-1:0]               op_pos;
  logic [plt_pkg::VALUE_W-1:0] op_val;

  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [plt_pkg::VALUE_W-1:0] rd_data, wr_data;

  logic                         done_next;
  logic [plt_pkg::STATUS_W-1:0] status_next;
  logic [plt_pkg::FOUND_W-1:0]  found_next;

  // Wide views for position and count arithmetic
  logic [PW-1:0] pos_w, pos_m1, cnt_w, ptr_w;
  logic [AW-1:0] p_idx;
  logic          is_full, ins_ok, del_ok, hit, accept;

  assign pos_w   = PW'(position);
  assign pos_m1  = pos_w - PW'(1);
  assign cnt_w   = PW'(cnt);
  assign ptr_w   = PW'(ptr);
  assign p_idx   = pos_m1[AW-1:0];
  assign is_full = (cnt == CW'(DEPTH));
  assign ins_ok  = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign del_ok  = (pos_w != '0) && (pos_w <= cnt_w);
  assign hit     = (rd_data == op_val);
  assign busy    = (state != plt_pkg::S_IDLE);
  assign accept  = start && !busy;

  plt_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      plt_pkg::S_IDLE: begin
        if (start) begin
          case (action)
            plt_pkg::ACT_INSERT: begin
              if (!is_full && ins_ok) state_next = plt_pkg::S_SHIFT_UP;
            end
            plt_pkg::ACT_DELETE: begin
              if (del_ok && (pos_w < cnt_w)) state_next = plt_pkg::S_SHIFT_DN;
            end
            plt_pkg::ACT_FIND: begin
              if (cnt != '0) state_next = plt_pkg::S_SCAN;
            end
            default: state_next = plt_pkg::S_IDLE;
          endcase
        end
      end
      plt_pkg::S_SHIFT_UP: begin
        if (ptr == op_pos) state_next = plt_pkg::S_IDLE;
      end
      plt_pkg::S_SHIFT_DN: begin
        if (ptr_w + PW'(2) >= cnt_w) state_next = plt_pkg::S_IDLE;
      end
      plt_pkg::S_SCAN: begin
        if (hit || (ptr_w + PW'(1) >= cnt_w)) state_next = plt_pkg::S_IDLE;
      end
      default: state_next = plt_pkg::S_IDLE;
    endcase
  end

  // Store accesses, pointer, count and result
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = ptr;
    wr_data     = rd_data;
    ptr_next    = ptr;
    cnt_next    = cnt;
    done_next   = 1'b0;
    status_next = plt_pkg::STAT_OK;
    found_next  = '0;
    case (state)
      plt_pkg::S_IDLE: begin
        if (start) begin
          case (action)
            plt_pkg::ACT_INSERT: begin
              if (is_full) begin
                done_next   = 1'b1;
                status_next = plt_pkg::STAT_FULL;
              end else if (!ins_ok) begin
                done_next   = 1'b1;
                status_next = plt_pkg::STAT_BAD_POS;
              end else begin
                // start at the slot past the end; fetch its lower neighbor unless appending
                ptr_next = cnt[AW-1:0];
                if (pos_m1 != cnt_w) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(cnt_w - PW'(1));
                end
              end
            end
            plt_pkg::ACT_DELETE: begin
              if (!del_ok) begin
                done_next   = 1'b1;
                status_next = plt_pkg::STAT_BAD_POS;
              end else if (pos_w < cnt_w) begin
                // fetch the entry above the hole
                ptr_next = p_idx;
                rd_en    = 1'b1;
                rd_addr  = pos_w[AW-1:0];
              end else begin
                // last entry: drop it without moving anything
                done_next = 1'b1;
                cnt_next  = cnt - CW'(1);
              end
            end
            plt_pkg::ACT_FIND: begin
              if (cnt == '0) begin
                done_next   = 1'b1;
                status_next = plt_pkg::STAT_NOT_FOUND;
              end else begin
                ptr_next = '0;
                rd_en    = 1'b1;
                rd_addr  = '0;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      plt_pkg::S_SHIFT_UP: begin
        wr_en = 1'b1;
        if (ptr == op_pos) begin
          // drop the new value into the opened slot
          wr_data   = op_val;
          cnt_next  = cnt + CW'(1);
          done_next = 1'b1;
        end else begin
          // move one entry up and fetch the next one below
          ptr_next = ptr - AW'(1);
          if ((ptr - AW'(1)) != op_pos) begin
            rd_en   = 1'b1;
            rd_addr = AW'(ptr_w - PW'(2));
          end
        end
      end
      plt_pkg::S_SHIFT_DN: begin
        // move one entry down and fetch the next one above
        wr_en = 1'b1;
        if (ptr_w + PW'(2) < cnt_w) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(ptr_w + PW'(2));
          ptr_next = ptr + AW'(1);
        end else begin
          cnt_next  = cnt - CW'(1);
          done_next = 1'b1;
        end
      end
      plt_pkg::S_SCAN: begin
        if (hit) begin
          done_next  = 1'b1;
          found_next = plt_pkg::FOUND_W'(ptr);
        end else if (ptr_w + PW'(1) >= cnt_w) begin
          done_next   = 1'b1;
          status_next = plt_pkg::STAT_NOT_FOUND;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = ptr + AW'(1);
          ptr_next = ptr + AW'(1);
        end
      end
      default: begin
        ptr_next = ptr;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plt_pkg::S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  // Command capture, walk pointer and result payload
  always_ff @(posedge clk) begin
    ptr         <= ptr_next;
    status      <= status_next;
    found_index <= found_next;
    entry_count <= plt_pkg::COUNT_W'(cnt_next);
    if (accept) begin
      op_pos <= p_idx;
      op_val <= item_value;
    end
  end

endmodule

`default_nettype wire

>>> rtl/plt_ram.sv
// Entry store of the positional list table: one write port and one
// read port with registered read data. Depends on plt_pkg.
`default_nettype none

module plt_ram #(
  parameter int DEPTH = plt_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [plt_pkg::VALUE_W-1:0]  rd_data,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [plt_pkg::VALUE_W-1:0]  wr_data
);

  logic [plt_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
